>>> src/bmhq_pkg.sv
// Shared constants, codes and sequencer states for the binary min-heap queue.
package bmhq_pkg;

    localparam int unsigned DEPTH_DEF     = 1024;
    localparam int unsigned KEY_WIDTH_DEF = 32;

    localparam int unsigned KEY_IO_W   = 32;
    localparam int unsigned STATUS_W   = 2;
    localparam int unsigned COUNT_IO_W = 11;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_POP_RD,
        S_POP_LD,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_RESP
    } state_t;

endpackage

>>> src/bmhq_req_if.sv
// Request channel: valid/ready handshake carrying one push or pop request.
interface bmhq_req_if;
    import bmhq_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [KEY_IO_W-1:0] key_in;

    modport source (output valid, output action, output key_in, input ready);
    modport sink   (input valid, input action, input key_in, output ready);
endinterface

>>> src/bmhq_rsp_if.sv
// Response channel: valid/ready handshake carrying one result per request.
interface bmhq_rsp_if;
    import bmhq_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [KEY_IO_W-1:0]   key_out;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_IO_W-1:0] entry_count;

    modport source (output valid, output key_out, output status, output entry_count,
                    input ready);
    modport sink   (input valid, input key_out, input status, input entry_count,
                    output ready);
endinterface

>>> src/binary_min_heap_queue_top.sv
// Binary min-heap priority queue: heap memory, sift sequencer and response register.
//
//   channel  dir  handshake     payload
//   -------  ---  ------------  ---------------------------------
//   req      in   valid/ready   action, key_in
//   rsp      out  valid/ready   key_out, status, entry_count
//
// One request at a time. A push climbs from a new hole at the end, a pop sinks from
// the root, and a dropped push or a pop on empty goes straight to the response. A pop
// sinks at most log2(DEPTH)-1 levels. The pace is set by the heap memory: one
// read-compare-write round trip per level through its registered read ports.
// Reset clears the entry count and the sequencer; the heap memory is not cleared.
// A full response register stalls only the final step; req.ready is high in idle.
module binary_min_heap_queue_top #(
    parameter int unsigned DEPTH     = bmhq_pkg::DEPTH_DEF,
    parameter int unsigned KEY_WIDTH = bmhq_pkg::KEY_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    bmhq_req_if.sink    req,
    bmhq_rsp_if.source  rsp
);
    import bmhq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);      // heap index
    localparam int unsigned CW = $clog2(DEPTH + 1);  // entry count, holds DEPTH
    localparam int unsigned IW = AW + 2;             // child index before range check
    localparam int unsigned KW = KEY_WIDTH;

    // Heap memory: one write port, two read ports with registered data.
    logic [KW-1:0] heap_mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [KW-1:0] mem_wd;
    logic [AW-1:0] mem_ra_a;
    logic [AW-1:0] mem_ra_b;
    logic [KW-1:0] rd_a_reg;
    logic [KW-1:0] rd_b_reg;

    // Sequencer state and working registers.
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] pos_reg, pos_next;        // current hole position while sifting
    logic [KW-1:0] key_reg, key_next;        // key being sifted
    logic [KW-1:0] res_key_reg, res_key_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;

    // Response register.
    logic                  rsp_valid_reg, rsp_valid_next;
    logic [KEY_IO_W-1:0]   rsp_key_reg, rsp_key_next;
    logic [STATUS_W-1:0]   rsp_status_reg, rsp_status_next;
    logic [COUNT_IO_W-1:0] rsp_count_reg, rsp_count_next;

    // Shared decode.
    logic          accept;
    logic          is_full;
    logic          is_empty;
    logic          rsp_free;
    logic [AW-1:0] parent_idx;
    logic          up_less;
    logic [IW-1:0] count_ext;
    logic [IW-1:0] lc_idx;
    logic [IW-1:0] rc_idx;
    logic          lc_ok;
    logic          rc_ok;
    logic          rc_take;
    logic          lc_take;
    logic [KW-1:0] pick_val;
    logic          moved;
    logic [KW-1:0] child_val;
    logic [AW-1:0] child_idx;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign is_full   = (count_reg == CW'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign rsp_free  = !rsp_valid_reg || rsp.ready;

    // Sift-up: compare the climbing key against the parent read last cycle.
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign up_less    = key_reg < rd_a_reg;

    // Sift-down: right child wins over the key on strict less-than, then the
    // left child wins over that choice on strict less-than.
    assign count_ext = IW'(count_reg);
    assign lc_idx    = IW'({pos_reg, 1'b1});
    assign rc_idx    = lc_idx + IW'(1);
    assign lc_ok     = lc_idx < count_ext;
    assign rc_ok     = rc_idx < count_ext;
    assign rc_take   = rc_ok && (rd_b_reg < key_reg);
    assign pick_val  = rc_take ? rd_b_reg : key_reg;
    assign lc_take   = lc_ok && (rd_a_reg < pick_val);
    assign moved     = rc_take || lc_take;
    assign child_val = lc_take ? rd_a_reg : rd_b_reg;
    assign child_idx = lc_take ? lc_idx[AW-1:0] : rc_idx[AW-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.action == ACT_PUSH)
                    begin
                        state_next = is_full ? S_RESP : S_UP_RD;
                    end
                    else
                    begin
                        state_next = is_empty ? S_RESP : S_POP_RD;
                    end
                end
            end
            S_UP_RD:
            begin
                state_next = (pos_reg == '0) ? S_RESP : S_UP_CMP;
            end
            S_UP_CMP:
            begin
                state_next = up_less ? S_UP_RD : S_RESP;
            end
            S_POP_RD:
            begin
                state_next = S_POP_LD;
            end
            S_POP_LD:
            begin
                state_next = is_empty ? S_RESP : S_DOWN_RD;
            end
            S_DOWN_RD:
            begin
                state_next = S_DOWN_CMP;
            end
            S_DOWN_CMP:
            begin
                state_next = moved ? S_DOWN_RD : S_RESP;
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory controls and datapath next values.
    always_comb
    begin
        mem_we          = 1'b0;
        mem_wa          = pos_reg;
        mem_wd          = key_reg;
        mem_ra_a        = '0;
        mem_ra_b        = '0;
        count_next      = count_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        res_key_next    = res_key_reg;
        res_status_next = res_status_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_key_next    = rsp_key_reg;
        rsp_status_next = rsp_status_reg;
        rsp_count_next  = rsp_count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_key_next    = '0;
                    res_status_next = ST_OK;
                    if (req.action == ACT_PUSH)
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            // Open a hole at the end and let the key climb.
                            count_next = count_reg + CW'(1);
                            pos_next   = count_reg[AW-1:0];
                            key_next   = KW'(req.key_in);
                        end
                    end
                    else
                    begin
                        if (is_empty)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            pos_next   = '0;
                        end
                    end
                end
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_ra_a = parent_idx;
                end
            end
            S_UP_CMP:
            begin
                mem_we = 1'b1;
                if (up_less)
                begin
                    // Drop the parent into the hole and move the hole up.
                    mem_wd   = rd_a_reg;
                    pos_next = parent_idx;
                end
            end
            S_POP_RD:
            begin
                // Fetch the root and the last entry, which now sits at the count.
                mem_ra_a = '0;
                mem_ra_b = count_reg[AW-1:0];
            end
            S_POP_LD:
            begin
                res_key_next = rd_a_reg;
                key_next     = rd_b_reg;
            end
            S_DOWN_RD:
            begin
                mem_ra_a = lc_ok ? lc_idx[AW-1:0] : '0;
                mem_ra_b = rc_ok ? rc_idx[AW-1:0] : '0;
            end
            S_DOWN_CMP:
            begin
                mem_we = 1'b1;
                if (moved)
                begin
                    // Lift the smaller child into the hole and move the hole down.
                    mem_wd   = child_val;
                    pos_next = child_idx;
                end
            end
            S_RESP:
            begin
                if (rsp_free)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_key_next    = KEY_IO_W'(res_key_reg);
                    rsp_status_next = res_status_reg;
                    rsp_count_next  = COUNT_IO_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Each level writes only at the hole and then reads below or above it, and
    // a new request reads no earlier than the cycle after the last write, so
    // the memory never sees a read and a write of the same entry overlap.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            heap_mem[mem_wa] <= mem_wd;
        end
        rd_a_reg <= heap_mem[mem_ra_a];
        rd_b_reg <= heap_mem[mem_ra_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        res_key_reg    <= res_key_next;
        res_status_reg <= res_status_next;
        rsp_key_reg    <= rsp_key_next;
        rsp_status_reg <= rsp_status_next;
        rsp_count_reg  <= rsp_count_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.key_out     = rsp_key_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.entry_count = rsp_count_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above heap depth");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (IW'(mem_wa) < count_ext))
        else $error("heap write outside the live entries");

    a_down_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DOWN_RD) |-> (IW'(pos_reg) < count_ext))
        else $error("sift-down hole outside the live entries");

    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_next && !rsp_valid_reg && (rsp_status_next == ST_EMPTY))
        |=> (rsp.entry_count == '0) && (rsp.key_out == '0))
        else $error("pop on empty reports keys or entries");
`endif

endmodule

>>> dv/testbench.sv
// Self-checking testbench for the binary min-heap priority queue.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bmhq_pkg::*;

    localparam int unsigned HEAP_DEPTH = DEPTH_DEF;
    // Quiet cycles tolerated before the run is declared hung. The longest
    // legal quiet stretch is the deliberate response hold-off below.
    localparam int unsigned QUIET_LIMIT = 4000;
    localparam int unsigned LONG_HOLD   = 300;
    // A pop sinks through at most log2(1024)-1 levels.
    localparam int unsigned SETTLE_CYCLES = 40;

    typedef struct {
        logic [KEY_IO_W-1:0]   key_out;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_IO_W-1:0] entry_count;
    } heap_reply_t;

    // Mirror of the heap contents, updated at each accepted request. The
    // expected reply is queued in request order and retired by each response.
    class min_heap_predictor;
        logic [KEY_IO_W-1:0] heap_keys [HEAP_DEPTH];
        int unsigned         fill;
        heap_reply_t         predicted_rsps [$];
        int unsigned         error_count;

        function new();
            fill        = 0;
            error_count = 0;
        endfunction

        function void swap_keys(input int unsigned a, input int unsigned b);
            logic [KEY_IO_W-1:0] t;
            t            = heap_keys[a];
            heap_keys[a] = heap_keys[b];
            heap_keys[b] = t;
        endfunction

        // Climb while strictly smaller than the parent.
        function void bubble_up(input int unsigned slot);
            int unsigned pos;
            int unsigned up;
            pos = slot;
            while (pos > 0) begin
                up = (pos - 1) / 2;
                if (heap_keys[pos] < heap_keys[up]) begin
                    swap_keys(pos, up);
                    pos = up;
                end else begin
                    break;
                end
            end
        endfunction

        // Sink toward the smaller child; the right child is tried first, so
        // on a tie between children the right one wins.
        function void bubble_down(input int unsigned slot);
            int unsigned pos;
            int unsigned lc;
            int unsigned rc;
            int unsigned pick;
            pos = slot;
            forever begin
                lc   = pos * 2 + 1;
                rc   = pos * 2 + 2;
                pick = pos;
                if (rc < fill && heap_keys[rc] < heap_keys[pos])
                    pick = rc;
                if (lc < fill && heap_keys[lc] < heap_keys[pick])
                    pick = lc;
                if (pick == pos)
                    break;
                swap_keys(pick, pos);
                pos = pick;
            end
        endfunction

        function void note_request(input logic act, input logic [KEY_IO_W-1:0] key);
            heap_reply_t r;
            r.key_out = '0;
            r.status  = ST_OK;
            if (act == ACT_PUSH) begin
                if (fill >= HEAP_DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    heap_keys[fill] = key;
                    fill++;
                    bubble_up(fill - 1);
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.key_out    = heap_keys[0];
                    fill--;
                    heap_keys[0] = heap_keys[fill];
                    bubble_down(0);
                end
            end
            r.entry_count = COUNT_IO_W'(fill);
            predicted_rsps.push_back(r);
        endfunction

        function void check_response(input logic [KEY_IO_W-1:0]   key_out,
                                     input logic [STATUS_W-1:0]   status,
                                     input logic [COUNT_IO_W-1:0] entry_count);
            heap_reply_t exp_r;
            if (predicted_rsps.size() == 0) begin
                $error("response with no request outstanding: key_out=%h status=%0d count=%0d",
                       key_out, status, entry_count);
                error_count++;
                return;
            end
            exp_r = predicted_rsps.pop_front();
            if (key_out !== exp_r.key_out) begin
                $error("key_out: expected %h, actual %h", exp_r.key_out, key_out);
                error_count++;
            end
            if (status !== exp_r.status) begin
                $error("status: expected %0d, actual %0d", exp_r.status, status);
                error_count++;
            end
            if (entry_count !== exp_r.entry_count) begin
                $error("entry_count: expected %0d, actual %0d", exp_r.entry_count, entry_count);
                error_count++;
            end
        endfunction

        function int unsigned outstanding();
            return predicted_rsps.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    bmhq_req_if req_ch ();
    bmhq_rsp_if rsp_ch ();

    binary_min_heap_queue_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    min_heap_predictor heap_model;

    // Random idling on both channels; cleared for the closing stretch.
    bit          idle_on;
    // Long response hold-off, handed to the receiver process.
    int unsigned hold_request;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the block takes it. An idle gap
    // lowers valid first; otherwise valid stays high from the last request.
    task automatic issue_request(input logic act, input logic [KEY_IO_W-1:0] key);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 15);
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid  <= 1'b1;
        req_ch.action <= act;
        req_ch.key_in <= key;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        heap_model.note_request(act, key);
    endtask

    task automatic push_key(input logic [KEY_IO_W-1:0] key);
        issue_request(ACT_PUSH, key);
    endtask

    // Drive a random key on a pop too: the block must ignore it.
    task automatic pop_min();
        issue_request(ACT_POP, $urandom());
    endtask

    // Keys: mostly full-range, often a narrow band so duplicates are common,
    // and now and then one of the extremes.
    function automatic logic [KEY_IO_W-1:0] pick_key();
        case ($urandom_range(0, 7)) inside
            0, 1:    return $urandom_range(0, 15);
            2: begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return '1;
                    2:       return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    // Random push/pop mix; push_pct sets the drift of the fill level.
    task automatic run_mix(input int unsigned count, input int unsigned push_pct);
        for (int unsigned n = 0; n < count; n++) begin
            if ($urandom_range(0, 99) < push_pct)
                push_key(pick_key());
            else
                pop_min();
        end
    endtask

    // Hold the sender until every outstanding response has come back.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (heap_model.outstanding() != 0) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: check each accepted response, then pick next ready.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned hold_left;
        int unsigned burst_left;
        hold_left    = 0;
        burst_left   = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                heap_model.check_response(rsp_ch.key_out, rsp_ch.status,
                                          rsp_ch.entry_count);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else if (burst_left != 0) begin
                burst_left--;
                rsp_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                burst_left   = $urandom_range(1, 15) - 1;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake on either channel counts as progress.
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        heap_model    = new();
        idle_on       = 1'b1;
        hold_request  = 0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.action = ACT_PUSH;
        req_ch.key_in = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: pop on empty, key extremes, equal keys, alternating bit
        // patterns, drain to empty and pop past it.
        pop_min();
        push_key(32'hFFFF_FFFF);
        push_key(32'h0000_0000);
        push_key(32'h0000_0000);
        push_key(32'h8000_0000);
        push_key(32'h0000_0001);
        push_key(32'h5555_5555);
        push_key(32'hAAAA_AAAA);
        push_key(32'hFFFF_FFFF);
        repeat (9) pop_min();
        // Equal children under a larger moved-up key: the tie goes to the
        // right child.
        push_key(32'd3);
        push_key(32'd5);
        push_key(32'd5);
        push_key(32'd7);
        push_key(32'd9);
        repeat (5) pop_min();
        wait_drained();

        // Block the response side for a long stretch while requests keep
        // coming, so the single request in flight backs up the input.
        hold_request = LONG_HOLD;
        run_mix(150, 60);
        wait_drained();

        // Fill to capacity with mostly pushes; switch idling on and off
        // every so often so there are calm stretches too.
        begin
            int unsigned n;
            n = 0;
            while (heap_model.fill < HEAP_DEPTH) begin
                if (n % 96 == 0)
                    idle_on = ($urandom_range(0, 2) != 0);
                if ($urandom_range(0, 99) < 95)
                    push_key(pick_key());
                else
                    pop_min();
                n++;
            end
        end
        idle_on = 1'b1;

        // Full heap: pushes must be dropped; a pop reopens exactly one slot.
        repeat (4) push_key(pick_key());
        pop_min();
        push_key(32'h0000_0000);
        push_key(32'h0000_0000);
        pop_min();
        push_key(32'hFFFF_FFFF);
        push_key(pick_key());
        wait_drained();

        // Deep sift-downs from a nearly full heap.
        run_mix(300, 15);
        wait_drained();

        // Closing stretch at full rate with no idling on either side.
        idle_on = 1'b0;
        run_mix(150, 45);
        req_ch.valid <= 1'b0;

        while (heap_model.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (heap_model.error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
